// ===== design/iptc_pkg.sv =====
// iptc_pkg: types, constants and group checks for the ip address text classifier
// used by every module of the classifier; depends on nothing
`default_nettype none

package iptc_pkg;

    localparam int LEN_W = 3;
    localparam int VAL_W = 10;
    localparam int DOT_W = 3;
    localparam int COL_W = 4;
    localparam int DIG_W = 4;

    localparam logic [LEN_W-1:0] LEN_SAT    = LEN_W'(5);
    localparam logic [LEN_W-1:0] V4_LEN_MAX = LEN_W'(3);
    localparam logic [LEN_W-1:0] V6_LEN_MAX = LEN_W'(4);
    localparam logic [VAL_W-1:0] V4_GROUP_MAX = VAL_W'(255);
    localparam logic [DOT_W-1:0] DOT_SAT  = DOT_W'(4);
    localparam logic [DOT_W-1:0] V4_DOTS  = DOT_W'(3);
    localparam logic [COL_W-1:0] COLON_SAT = COL_W'(8);
    localparam logic [COL_W-1:0] V6_COLONS = COL_W'(7);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;

    typedef enum logic [2:0] {
        KIND_DIGIT,
        KIND_HEX,
        KIND_DOT,
        KIND_COLON,
        KIND_OTHER
    } iptc_kind_t;

    typedef enum logic [1:0] {
        CLASS_NEITHER = 2'd0,
        CLASS_V4      = 2'd1,
        CLASS_V6      = 2'd2
    } iptc_class_t;

    typedef struct packed {
        iptc_kind_t       kind;
        logic [DIG_W-1:0] digit;
        logic             last;
    } iptc_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } iptc_qstat_t;

    function automatic logic group_ok_v4(input logic [LEN_W-1:0] len,
                                         input logic [VAL_W-1:0] val,
                                         input logic             starts_zero);
        logic ok;
        ok = (len != '0) && (len <= V4_LEN_MAX) && (val <= V4_GROUP_MAX)
             && !(starts_zero && (len > LEN_W'(1)));
        return ok;
    endfunction

    function automatic logic group_ok_v6(input logic [LEN_W-1:0] len);
        logic ok;
        ok = (len != '0) && (len <= V6_LEN_MAX);
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== design/iptc_front.sv =====
// iptc_front: sorts each incoming character beat into digit, hex, dot, colon or other
// depends on iptc_pkg; feeds iptc_queue
`default_nettype none

module iptc_front
    import iptc_pkg::*;
(
    input  wire logic       char_valid,
    input  wire logic [7:0] char_code,
    input  wire logic       last_char,
    input  wire logic       q_full,
    output logic            push,
    output iptc_item_t      item
);

    always_comb
    begin
        item.last  = last_char;
        item.digit = char_code[DIG_W-1:0];
        case (char_code) inside
            [CH_0:CH_9]:                    item.kind = KIND_DIGIT;
            [CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]: item.kind = KIND_HEX;
            CH_DOT:                         item.kind = KIND_DOT;
            CH_COLON:                       item.kind = KIND_COLON;
            default:                        item.kind = KIND_OTHER;
        endcase
    end

    assign push = char_valid && !q_full;

endmodule

`default_nettype wire

// ===== design/iptc_queue.sv =====
// iptc_queue: short register queue of classified characters between front and back
// depends on iptc_pkg
`default_nettype none

module iptc_queue
    import iptc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire iptc_item_t  push_item,
    input  wire logic        pop,
    output iptc_qstat_t      status,
    output iptc_item_t       head
);

    iptc_item_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ===== design/iptc_back.sv =====
// iptc_back: group counters and validity flags, verdict register on the last character
// depends on iptc_pkg; drains iptc_queue
`default_nettype none

module iptc_back
    import iptc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire iptc_qstat_t q_status,
    input  wire iptc_item_t  head,
    output logic             pop,
    output logic             class_valid,
    input  wire logic        class_stall,
    output logic [1:0]       address_class
);

    logic              v4_reg, v4_next;
    logic              v6_reg, v6_next;
    logic [COL_W-1:0]  colon_reg, colon_next;
    logic [DOT_W-1:0]  dot_reg, dot_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic              sz_reg, sz_next;
    logic              valid_reg, valid_next;
    iptc_class_t       class_reg, class_next;

    logic [LEN_W-1:0]  len_inc;
    iptc_class_t       verdict;

    // a non-last beat never needs the output register, so it drains freely
    assign pop = !q_status.empty && (!head.last || !valid_reg || !class_stall);

    always_comb
    begin
        len_inc    = (len_reg < LEN_SAT) ? len_reg + LEN_W'(1) : len_reg;
        v4_next    = v4_reg;
        v6_next    = v6_reg;
        colon_next = colon_reg;
        dot_next   = dot_reg;
        len_next   = len_reg;
        val_next   = val_reg;
        sz_next    = sz_reg;
        case (head.kind)
            KIND_DIGIT:
            begin
                if (len_reg == '0)
                    sz_next = (head.digit == '0);
                if (len_reg < V4_LEN_MAX)
                    val_next = (val_reg << 3) + (val_reg << 1) + VAL_W'(head.digit);
                len_next = len_inc;
            end
            KIND_HEX:
            begin
                v4_next  = 1'b0;
                len_next = len_inc;
            end
            KIND_DOT:
            begin
                v6_next = 1'b0;
                if (!group_ok_v4(len_reg, val_reg, sz_reg))
                    v4_next = 1'b0;
                if (dot_reg < DOT_SAT)
                    dot_next = dot_reg + DOT_W'(1);
                len_next = '0;
                val_next = '0;
                sz_next  = 1'b0;
            end
            KIND_COLON:
            begin
                v4_next = 1'b0;
                if (!group_ok_v6(len_reg))
                    v6_next = 1'b0;
                if (colon_reg < COLON_SAT)
                    colon_next = colon_reg + COL_W'(1);
                len_next = '0;
                val_next = '0;
                sz_next  = 1'b0;
            end
            default:
            begin
                v4_next = 1'b0;
                v6_next = 1'b0;
            end
        endcase

        if (v4_next && dot_next == V4_DOTS && colon_next == '0
            && group_ok_v4(len_next, val_next, sz_next))
            verdict = CLASS_V4;
        else if (v6_next && colon_next == V6_COLONS && dot_next == '0
                 && group_ok_v6(len_next))
            verdict = CLASS_V6;
        else
            verdict = CLASS_NEITHER;

        // string done: back to the empty-string state
        if (head.last)
        begin
            v4_next    = 1'b1;
            v6_next    = 1'b1;
            colon_next = '0;
            dot_next   = '0;
            len_next   = '0;
            val_next   = '0;
            sz_next    = 1'b0;
        end

        valid_next = valid_reg && class_stall;
        class_next = class_reg;
        if (pop && head.last)
        begin
            valid_next = 1'b1;
            class_next = verdict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg    <= 1'b1;
            v6_reg    <= 1'b1;
            colon_reg <= '0;
            dot_reg   <= '0;
            len_reg   <= '0;
            val_reg   <= '0;
            sz_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                v4_reg    <= v4_next;
                v6_reg    <= v6_next;
                colon_reg <= colon_next;
                dot_reg   <= dot_next;
                len_reg   <= len_next;
                val_reg   <= val_next;
                sz_reg    <= sz_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        class_reg <= class_next;
    end

    assign class_valid   = valid_reg;
    assign address_class = class_reg;

endmodule

`default_nettype wire

// ===== design/ip_address_text_classifier.sv =====
// ip_address_text_classifier: top level, front decoder, queue and back classifier
// depends on iptc_pkg, iptc_front, iptc_queue, iptc_back
//
// Takes one character beat per cycle (char_code, last_char) while char_stall is low, and gives
// one verdict beat (address_class: 0 neither, 1 IPv4, 2 IPv6) for each beat flagged last_char.
// Characters are sorted by the front and held in a two-entry queue; the back updates the group
// counters at one beat per cycle while it is not stalled and registers the verdict when the
// last character is popped from the queue. The back stalls only on a last beat while an earlier
// verdict is still held, so char_stall rises only after the queue fills behind a held verdict.
`default_nettype none

module ip_address_text_classifier
    import iptc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_stall,
    input  wire logic [7:0] char_code,
    input  wire logic       last_char,
    output logic            class_valid,
    input  wire logic       class_stall,
    output logic [1:0]      address_class
);

    iptc_item_t  push_item;
    iptc_item_t  head;
    iptc_qstat_t q_status;
    logic        push;
    logic        pop;

    iptc_front u_front (
        .char_valid (char_valid),
        .char_code  (char_code),
        .last_char  (last_char),
        .q_full     (q_status.full),
        .push       (push),
        .item       (push_item)
    );

    iptc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .status    (q_status),
        .head      (head)
    );

    iptc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head          (head),
        .pop           (pop),
        .class_valid   (class_valid),
        .class_stall   (class_stall),
        .address_class (address_class)
    );

    assign char_stall = q_status.full;

endmodule

`default_nettype wire

// ===== design/iptc_checker.sv =====
// iptc_checker: port-level assertions for the ip address text classifier
// depends on nothing; bound to ip_address_text_classifier
`default_nettype none

module iptc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       char_valid,
    input wire logic       char_stall,
    input wire logic [7:0] char_code,
    input wire logic       last_char,
    input wire logic       class_valid,
    input wire logic       class_stall,
    input wire logic [1:0] address_class
);

    // verdict code three is never produced
    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        class_valid |-> (address_class != 2'd3))
        else $error("iptc: undefined address class");

    // the queue only fills behind a verdict that is being held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> class_valid)
        else $error("iptc: input stalled with no verdict pending");

    // a stalled verdict beat stays and holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        class_valid && class_stall |=> class_valid && $stable(address_class))
        else $error("iptc: stalled verdict changed");

endmodule

bind ip_address_text_classifier iptc_checker u_iptc_checker (.*);

`default_nettype wire
